FILE: src/cstok_pkg.sv
`timescale 1ns / 1ps

package cstok_pkg;

  localparam int MaxResults = 5;
  localparam int BufDepth   = 8;
  localparam int CntW       = $clog2(BufDepth + 1);
  localparam int ResCntW    = $clog2(MaxResults + 1);

  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;

  typedef enum logic [2:0] {
    MODE_GAP    = 3'd0,
    MODE_BARE   = 3'd1,
    MODE_QUOTED = 3'd2,
    MODE_LINE   = 3'd3,
    MODE_BLOCK  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_END_TOKEN = 2'd1,
    KIND_END_TEXT  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic       quoted;
    logic       run_last;
  } result_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] held_byte;
    logic [1:0] held_count;
    logic       star_seen;
  } lex_state_t;

  typedef struct packed {
    result_t [MaxResults-1:0] res;
    logic [ResCntW-1:0]       count;
  } step_out_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_LF) || (b == CH_CR) || (b == CH_SPACE) || (b == CH_TAB);
  endfunction

endpackage

FILE: src/comment_skipping_text_tokenizer.sv
`timescale 1ns / 1ps
// Channel  | Ports         | Contents
// ---------+---------------+------------------------------------------------
// input    | in_t*         | tdata[7:0] text byte, tlast final byte of text
// result   | out_t*        | tdata[7:0] value, tuser[1:0] kind,
//          |               | tuser[2] quoted, tlast last result of a byte
//
// One text byte is taken per clock while in_tready is high; its results
// (zero to five) are written in that cycle into an 8-entry result buffer
// that drains one per clock while out_tready is high. in_tready is high
// while the buffer holds three results or fewer, so bytes that give at most
// one result stream at full rate; the output drain sets the rate otherwise.
// Reset (rst_n low, synchronous) holds in_tready low, empties the buffer and
// returns the scanner to between tokens. A stalled output holds its result.

module comment_skipping_text_tokenizer import cstok_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tlast,   // is_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] value
  output logic [2:0] out_tuser,  // [1:0] kind, [2] quoted
  output logic       out_tlast   // run_last
);

  lex_state_t state_r;
  lex_state_t state_nxt;
  step_out_t  step_res;
  result_t    head;
  logic       accept;
  logic       room;

  assign in_tready = room && rst_n;
  assign accept    = in_tvalid && in_tready;

  cstok_step u_step (
    .cur     (state_r),
    .byte_in (in_tdata),
    .last_in (in_tlast),
    .nxt     (state_nxt),
    .so      (step_res)
  );

  cstok_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (step_res),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (head)
  );

  // advance scanner state only on an accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{MODE_GAP, 8'd0, 2'd0, 1'b0};
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  assign out_tdata = head.value;
  assign out_tuser = {head.quoted, head.kind};
  assign out_tlast = head.run_last;

endmodule

FILE: src/cstok_step.sv
`timescale 1ns / 1ps

module cstok_step import cstok_pkg::*; (
  input  lex_state_t cur,
  input  logic [7:0] byte_in,
  input  logic       last_in,
  output lex_state_t nxt,
  output step_out_t  so
);

  always_comb begin
    logic [ResCntW-1:0] n;
    n = '0;
    so = '0;
    nxt = cur;

    case (cur.mode)
      MODE_BARE: begin
        if (is_space(byte_in)) begin
          so.res[n] = '{KIND_END_TOKEN, 8'd0, 1'b0, 1'b0};
          n = n + 1'b1;
          nxt.mode = MODE_GAP;
        end else begin
          so.res[n] = '{KIND_BYTE, byte_in, 1'b0, 1'b0};
          n = n + 1'b1;
        end
      end
      MODE_QUOTED: begin
        if (byte_in == CH_QUOTE) begin
          so.res[n] = '{KIND_END_TOKEN, 8'd0, 1'b1, 1'b0};
          n = n + 1'b1;
          nxt.mode = MODE_GAP;
        end else begin
          so.res[n] = '{KIND_BYTE, byte_in, 1'b1, 1'b0};
          n = n + 1'b1;
        end
      end
      MODE_LINE: begin
        if (byte_in == CH_LF || byte_in == CH_CR) begin
          nxt.mode = MODE_GAP;
        end
      end
      MODE_BLOCK: begin
        if (cur.star_seen && byte_in == CH_SLASH) begin
          nxt.mode = MODE_GAP;
          nxt.star_seen = 1'b0;
        end else begin
          nxt.star_seen = (byte_in == CH_STAR);
        end
      end
      default: begin
        // between tokens; stray codes fall here too
        nxt.mode = MODE_GAP;
        nxt.held_count = 2'd0;
        if (cur.held_count == 2'd1) begin
          if (cur.held_byte == CH_SLASH && byte_in == CH_STAR) begin
            nxt.mode = MODE_BLOCK;
            nxt.star_seen = 1'b0;
          end else if (cur.held_byte == CH_SLASH && byte_in == CH_SLASH) begin
            nxt.held_count = 2'd2;
          end else if (cur.held_byte == CH_HASH && byte_in == CH_HASH) begin
            nxt.mode = MODE_LINE;
          end else begin
            // flush the held byte, then treat this one as inside a token
            so.res[n] = '{KIND_BYTE, cur.held_byte, 1'b0, 1'b0};
            n = n + 1'b1;
            if (is_space(byte_in)) begin
              so.res[n] = '{KIND_END_TOKEN, 8'd0, 1'b0, 1'b0};
              n = n + 1'b1;
            end else begin
              so.res[n] = '{KIND_BYTE, byte_in, 1'b0, 1'b0};
              n = n + 1'b1;
              nxt.mode = MODE_BARE;
            end
          end
        end else if (cur.held_count == 2'd2) begin
          if (byte_in == CH_DOLLAR) begin
            so.res[n] = '{KIND_BYTE, CH_SLASH, 1'b0, 1'b0};
            n = n + 1'b1;
            so.res[n] = '{KIND_BYTE, CH_SLASH, 1'b0, 1'b0};
            n = n + 1'b1;
            so.res[n] = '{KIND_BYTE, CH_DOLLAR, 1'b0, 1'b0};
            n = n + 1'b1;
            nxt.mode = MODE_BARE;
          end else if (byte_in != CH_LF && byte_in != CH_CR) begin
            nxt.mode = MODE_LINE;
          end
        end else begin
          if (is_space(byte_in)) begin
            nxt.mode = MODE_GAP;
          end else if (byte_in == CH_SLASH || byte_in == CH_HASH) begin
            nxt.held_byte = byte_in;
            nxt.held_count = 2'd1;
          end else if (byte_in == CH_QUOTE) begin
            nxt.mode = MODE_QUOTED;
          end else begin
            so.res[n] = '{KIND_BYTE, byte_in, 1'b0, 1'b0};
            n = n + 1'b1;
            nxt.mode = MODE_BARE;
          end
        end
      end
    endcase

    if (last_in) begin
      if (nxt.mode == MODE_GAP && nxt.held_count == 2'd1) begin
        so.res[n] = '{KIND_BYTE, nxt.held_byte, 1'b0, 1'b0};
        n = n + 1'b1;
        so.res[n] = '{KIND_END_TOKEN, 8'd0, 1'b0, 1'b0};
        n = n + 1'b1;
      end
      if (nxt.mode == MODE_BARE) begin
        so.res[n] = '{KIND_END_TOKEN, 8'd0, 1'b0, 1'b0};
        n = n + 1'b1;
      end else if (nxt.mode == MODE_QUOTED) begin
        so.res[n] = '{KIND_END_TOKEN, 8'd0, 1'b1, 1'b0};
        n = n + 1'b1;
      end
      so.res[n] = '{KIND_END_TEXT, 8'd0, 1'b0, 1'b0};
      n = n + 1'b1;
      nxt = '{MODE_GAP, 8'd0, 2'd0, 1'b0};
    end

    // mark the final result of this byte
    for (int i = 0; i < MaxResults; i++) begin
      so.res[i].run_last = (n != '0) && (ResCntW'(i) == n - 1'b1);
    end
    so.count = n;
  end

endmodule

FILE: src/cstok_obuf.sv
`timescale 1ns / 1ps

module cstok_obuf import cstok_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  step_out_t push_data,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   out_res
);

  result_t         buf_r [BufDepth];
  result_t         buf_nxt [BufDepth];
  logic [CntW-1:0] cnt_r;
  logic [CntW-1:0] cnt_nxt;
  logic            pop;
  logic [CntW-1:0] base;

  assign out_valid = (cnt_r != '0);
  assign out_res   = buf_r[0];
  assign pop       = out_valid && out_ready;
  assign room      = (cnt_r <= CntW'(BufDepth - MaxResults));
  assign base      = cnt_r - CntW'(pop);

  always_comb begin
    logic [CntW-1:0] idx;
    for (int i = 0; i < BufDepth; i++) begin
      // shift down on pop, then append new results after the survivors
      if (pop && i < BufDepth - 1) begin
        buf_nxt[i] = buf_r[(i + 1) % BufDepth];
      end else begin
        buf_nxt[i] = buf_r[i];
      end
      idx = CntW'(i) - base;
      if (push && CntW'(i) >= base && idx < CntW'(push_data.count)) begin
        buf_nxt[i] = push_data.res[idx[ResCntW-1:0]];
      end
    end
    cnt_nxt = base + (push ? CntW'(push_data.count) : '0);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < BufDepth; i++) begin
      buf_r[i] <= buf_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cstok_pkg::*;

  localparam int ResetCycles = 8;
  localparam int WatchLimit  = 2000;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 20;
  localparam int TargetBytes = 420;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] text_byte
  logic       in_tlast;   // is_last
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] value
  logic [2:0] out_tuser;  // [1:0] kind, [2] quoted
  logic       out_tlast;  // run_last

  comment_skipping_text_tokenizer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  function automatic bit is_separator(logic [7:0] ch);
    return (ch == CH_LF) || (ch == CH_CR) || (ch == CH_SPACE) || (ch == CH_TAB);
  endfunction

  class token_tracker;
    mode_t      mode;
    logic [7:0] held_ch;
    logic [1:0] held_cnt;
    logic       star;
    result_t    step_q[$];
    result_t    pending_tokens[$];
    int         mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      mode     = MODE_GAP;
      held_ch  = 8'd0;
      held_cnt = 2'd0;
      star     = 1'b0;
    endfunction

    function void emit(kind_t k, logic [7:0] v, logic q);
      result_t r;
      r.kind     = k;
      r.value    = v;
      r.quoted   = q;
      r.run_last = 1'b0;
      if (step_q.size() < MaxResults) step_q.push_back(r);
    endfunction

    function void in_token(logic [7:0] ch);
      if (is_separator(ch)) begin
        emit(KIND_END_TOKEN, 8'd0, 1'b0);
        mode = MODE_GAP;
      end else begin
        emit(KIND_BYTE, ch, 1'b0);
        mode = MODE_BARE;
      end
    endfunction

    function void between_tokens(logic [7:0] ch);
      if (held_cnt == 2'd1) begin
        held_cnt = 2'd0;
        if (held_ch == CH_SLASH && ch == CH_STAR) begin
          mode = MODE_BLOCK;
          star = 1'b0;
        end else if (held_ch == CH_SLASH && ch == CH_SLASH) begin
          held_cnt = 2'd2;
        end else if (held_ch == CH_HASH && ch == CH_HASH) begin
          mode = MODE_LINE;
        end else begin
          emit(KIND_BYTE, held_ch, 1'b0);
          in_token(ch);
        end
      end else if (held_cnt == 2'd2) begin
        held_cnt = 2'd0;
        // "//$" is a token, not a comment
        if (ch == CH_DOLLAR) begin
          emit(KIND_BYTE, CH_SLASH, 1'b0);
          emit(KIND_BYTE, CH_SLASH, 1'b0);
          emit(KIND_BYTE, CH_DOLLAR, 1'b0);
          mode = MODE_BARE;
        end else if (ch == CH_LF || ch == CH_CR) begin
          mode = MODE_GAP;
        end else begin
          mode = MODE_LINE;
        end
      end else begin
        held_cnt = 2'd0;
        if (is_separator(ch)) begin
        end else if (ch == CH_SLASH || ch == CH_HASH) begin
          held_ch  = ch;
          held_cnt = 2'd1;
        end else if (ch == CH_QUOTE) begin
          mode = MODE_QUOTED;
        end else begin
          emit(KIND_BYTE, ch, 1'b0);
          mode = MODE_BARE;
        end
      end
    endfunction

    function void note_byte(logic [7:0] ch, logic last);
      step_q.delete();
      case (mode)
        MODE_BARE: in_token(ch);
        MODE_QUOTED: begin
          if (ch == CH_QUOTE) begin
            emit(KIND_END_TOKEN, 8'd0, 1'b1);
            mode = MODE_GAP;
          end else begin
            emit(KIND_BYTE, ch, 1'b1);
          end
        end
        MODE_LINE: begin
          if (ch == CH_LF || ch == CH_CR) mode = MODE_GAP;
        end
        MODE_BLOCK: begin
          if (star && ch == CH_SLASH) begin
            mode = MODE_GAP;
            star = 1'b0;
          end else begin
            star = (ch == CH_STAR);
          end
        end
        default: between_tokens(ch);
      endcase
      if (last) begin
        // resolve a lone held opener, close any open token, then mark end of text
        if (mode == MODE_GAP && held_cnt == 2'd1) begin
          emit(KIND_BYTE, held_ch, 1'b0);
          emit(KIND_END_TOKEN, 8'd0, 1'b0);
        end
        if (mode == MODE_BARE) emit(KIND_END_TOKEN, 8'd0, 1'b0);
        else if (mode == MODE_QUOTED) emit(KIND_END_TOKEN, 8'd0, 1'b1);
        emit(KIND_END_TEXT, 8'd0, 1'b0);
        clear();
      end
      if (step_q.size() > 0) step_q[step_q.size()-1].run_last = 1'b1;
      foreach (step_q[i]) pending_tokens.push_back(step_q[i]);
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] value, logic quoted,
                               logic run_last);
      result_t exp;
      if (pending_tokens.size() == 0) begin
        $error("unexpected result: kind %0d value 0x%02h quoted %0d run_last %0d",
               kind, value, quoted, run_last);
        mismatches++;
        return;
      end
      exp = pending_tokens.pop_front();
      if (kind != exp.kind) begin
        $error("kind: expected %0d, actual %0d", exp.kind, kind);
        mismatches++;
      end
      if (value != exp.value) begin
        $error("value: expected 0x%02h, actual 0x%02h", exp.value, value);
        mismatches++;
      end
      if (quoted != exp.quoted) begin
        $error("quoted: expected %0d, actual %0d", exp.quoted, quoted);
        mismatches++;
      end
      if (run_last != exp.run_last) begin
        $error("run_last: expected %0d, actual %0d", exp.run_last, run_last);
        mismatches++;
      end
    endfunction
  endclass

  token_tracker tracker;
  logic [7:0]   text_buf[$];
  int           bytes_sent;
  int           results_seen;
  int           idle_cycles;
  bit           steady;
  bit           long_hold_done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_any_except(logic [7:0] a, logic [7:0] b,
                                                 logic [7:0] c);
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255)); while (ch == a || ch == b || ch == c);
    return ch;
  endfunction

  function automatic logic [7:0] pick_word_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 8'($urandom_range(8'h61, 8'h7A));
    if (r < 8) begin
      case ($urandom_range(0, 4))
        0: return CH_SLASH;
        1: return CH_HASH;
        2: return CH_STAR;
        3: return CH_DOLLAR;
        default: return 8'h21;
      endcase
    end
    return pick_any_except(CH_QUOTE, CH_SPACE, CH_TAB) == CH_LF ? 8'h7E :
           pick_any_except(CH_QUOTE, CH_LF, CH_CR);
  endfunction

  function automatic logic [7:0] pick_separator();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic void add_word(int len);
    for (int i = 0; i < len; i++) begin
      logic [7:0] ch;
      ch = pick_word_char();
      if (is_separator(ch)) ch = 8'h5F;
      text_buf.push_back(ch);
    end
  endfunction

  function automatic void build_text();
    int pieces;
    pieces = $urandom_range(1, 8);
    for (int p = 0; p < pieces; p++) begin
      int n;
      n = $urandom_range(0, 5);
      case ($urandom_range(0, 7))
        0, 1: add_word(n + 1);
        2: begin
          text_buf.push_back(CH_QUOTE);
          for (int i = 0; i < n; i++)
            text_buf.push_back(pick_any_except(CH_QUOTE, CH_QUOTE, CH_QUOTE));
          if ($urandom_range(0, 7) != 0) text_buf.push_back(CH_QUOTE);
        end
        3: begin
          if ($urandom_range(0, 1)) begin
            text_buf.push_back(CH_SLASH);
            text_buf.push_back(CH_SLASH);
          end else begin
            text_buf.push_back(CH_HASH);
            text_buf.push_back(CH_HASH);
          end
          for (int i = 0; i < n; i++)
            text_buf.push_back(pick_any_except(CH_LF, CH_CR, CH_DOLLAR));
          text_buf.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
        end
        4: begin
          text_buf.push_back(CH_SLASH);
          text_buf.push_back(CH_STAR);
          for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
              0: text_buf.push_back(CH_STAR);
              1: text_buf.push_back(8'h61);
              default: text_buf.push_back(pick_any_except(CH_SLASH, CH_SLASH, CH_SLASH));
            endcase
          end
          text_buf.push_back(CH_STAR);
          text_buf.push_back(CH_SLASH);
        end
        5: begin
          text_buf.push_back(CH_SLASH);
          text_buf.push_back(CH_SLASH);
          text_buf.push_back(CH_DOLLAR);
          add_word(n % 4);
        end
        6: begin
          for (int i = 0; i <= n % 3; i++) text_buf.push_back(8'($urandom_range(0, 255)));
        end
        default: text_buf.push_back(pick_separator());
      endcase
      if ($urandom_range(0, 3) != 0) text_buf.push_back(pick_separator());
    end
  endfunction

  task automatic send_byte(logic [7:0] ch, logic last);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    tracker.note_byte(ch, last);
    bytes_sent++;
  endtask

  // send the buffered text, marking its final byte, and empty the buffer
  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++)
      send_byte(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  // result side: random stalls, plus one long hold once traffic is flowing
  initial begin
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      if (!long_hold_done && results_seen >= 60) begin
        long_hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_result(out_tuser[1:0], out_tdata, out_tuser[2], out_tlast);
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    tracker        = new();
    bytes_sent     = 0;
    results_seen   = 0;
    idle_cycles    = 0;
    steady         = 1'b0;
    long_hold_done = 1'b0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= 8'd0;
    in_tlast   <= 1'b0;
    out_tready <= 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // byte extremes, empty and spaced quoted strings, a token right after a
    // closing quote, //$ ended by LF, ## ended by CR, block comment
    text_buf = '{8'h00, 8'hFF, CH_SPACE, CH_QUOTE, CH_QUOTE, CH_QUOTE, "a", CH_TAB,
                 CH_QUOTE, "b", CH_SPACE, CH_SLASH, CH_SLASH, CH_DOLLAR, CH_LF,
                 CH_HASH, CH_HASH, CH_CR, CH_SLASH, CH_STAR, CH_STAR, CH_SLASH};
    send_text();
    // end word as plain text, then a lone held slash at end of text
    text_buf = '{"!", "E", "N", "D", CH_SPACE, CH_SLASH};
    send_text();
    // unterminated quoted string
    text_buf = '{CH_QUOTE, "q"};
    send_text();
    // held "//" at end of text counts as a comment
    text_buf = '{CH_SLASH, CH_SLASH};
    send_text();
    // block comment still open at end of text
    text_buf = '{CH_SLASH, CH_STAR};
    send_text();

    while (bytes_sent < TargetBytes) begin
      steady = ($urandom_range(0, 3) == 0);
      build_text();
      send_text();
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    while (tracker.pending_tokens.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_tokens.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/cstok_pkg.sv
src/cstok_step.sv
src/cstok_obuf.sv
src/comment_skipping_text_tokenizer.sv
test/testbench.sv
